// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int SPQ_DEPTH_DEFAULT = 16;
    localparam int SPQ_DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LIST   = 2'd2
    } spq_action_t;

    typedef enum logic [1:0] {
        STAT_ENTRY    = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_ACCEPTED = 2'd3
    } spq_status_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_EMPTY  = 3'd4,
        CMD_FULL   = 3'd5
    } spq_op_t;

    typedef struct packed {
        spq_op_t op;
        logic    list_last;
    } spq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
    } spq_stat_t;

endpackage

// ===== hw/rtl/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT,
    localparam int IdxW = $clog2(QUEUE_DEPTH),
    localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_action,
    input  spq_stat_t        stat,
    input  logic [CntW-1:0]  count,
    output spq_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             at_end;

    assign at_end = (CntW'(idx_reg) + CntW'(1)) == count;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.op        = CMD_NONE;
        cmd.list_last = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = stat.out_free;
                idx_next = '0;
                if (s_tvalid && stat.out_free) begin
                    case (s_action)
                        ACT_INSERT: begin
                            cmd.op = stat.full ? CMD_FULL : CMD_INSERT;
                        end
                        ACT_REMOVE: begin
                            cmd.op = stat.empty ? CMD_EMPTY : CMD_REMOVE;
                        end
                        ACT_LIST: begin
                            if (stat.empty) begin
                                cmd.op = CMD_EMPTY;
                            end else begin
                                state_next = ST_LIST;
                            end
                        end
                        default: begin
                            cmd.op = CMD_NONE;
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (stat.out_free) begin
                    cmd.op        = CMD_LIST;
                    cmd.list_last = at_end;
                    idx_next      = idx_reg + IdxW'(1);
                    if (at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/spq_datapath.sv =====
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT,
    localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spq_cmd_t                     cmd,
    input  logic signed [SPQ_DATA_W-1:0] in_value,
    input  logic signed [SPQ_DATA_W-1:0] in_priority,
    output spq_stat_t                    stat,
    output logic [CntW-1:0]              count,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic signed [SPQ_DATA_W-1:0] m_value,
    output logic signed [SPQ_DATA_W-1:0] m_priority,
    output logic [1:0]                   m_status,
    output logic                         m_last
);

    logic signed [SPQ_DATA_W-1:0] val_reg [QUEUE_DEPTH];
    logic signed [SPQ_DATA_W-1:0] pri_reg [QUEUE_DEPTH];
    logic signed [SPQ_DATA_W-1:0] val_next [QUEUE_DEPTH];
    logic signed [SPQ_DATA_W-1:0] pri_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       sel;
    logic [CntW-1:0]              count_reg, count_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [SPQ_DATA_W-1:0] out_val_reg, out_val_next;
    logic signed [SPQ_DATA_W-1:0] out_pri_reg, out_pri_next;
    logic [1:0]                   out_stat_reg, out_stat_next;
    logic                         out_last_reg, out_last_next;

    assign count         = count_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.empty    = count_reg == '0;
    assign stat.full     = count_reg == CntW'(QUEUE_DEPTH);

    // Each cell holds one entry; cells from the insert position onward take the new
    // entry or their lower neighbor, removes and listing pull from the upper neighbor.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic signed [SPQ_DATA_W-1:0] prv_val, prv_pri, nxt_val, nxt_pri;
        logic                         is_pos;

        assign sel[g] = (CntW'(g) >= count_reg) || (pri_reg[g] <= in_priority);

        if (g == 0) begin : g_first
            assign prv_val = in_value;
            assign prv_pri = in_priority;
            assign is_pos  = sel[g];
        end else begin : g_rest
            assign prv_val = val_reg[g-1];
            assign prv_pri = pri_reg[g-1];
            assign is_pos  = sel[g] && !sel[g-1];
        end

        if (g < QUEUE_DEPTH - 1) begin : g_has_next
            assign nxt_val = val_reg[g+1];
            assign nxt_pri = pri_reg[g+1];
        end else begin : g_no_next
            assign nxt_val = val_reg[g];
            assign nxt_pri = pri_reg[g];
        end

        always_comb begin
            val_next[g] = val_reg[g];
            pri_next[g] = pri_reg[g];
            case (cmd.op)
                CMD_INSERT: begin
                    if (is_pos) begin
                        val_next[g] = in_value;
                        pri_next[g] = in_priority;
                    end else if (sel[g]) begin
                        val_next[g] = prv_val;
                        pri_next[g] = prv_pri;
                    end
                end
                CMD_REMOVE: begin
                    val_next[g] = nxt_val;
                    pri_next[g] = nxt_pri;
                end
                CMD_LIST: begin
                    if (CntW'(g + 1) == count_reg) begin
                        val_next[g] = val_reg[0];
                        pri_next[g] = pri_reg[0];
                    end else if (CntW'(g + 1) < count_reg) begin
                        val_next[g] = nxt_val;
                        pri_next[g] = nxt_pri;
                    end
                end
                default: begin
                    val_next[g] = val_reg[g];
                    pri_next[g] = pri_reg[g];
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            val_reg[g] <= val_next[g];
            pri_reg[g] <= pri_next[g];
        end
    end

    always_comb begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_pri_next   = out_pri_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        if (cmd.op != CMD_NONE) begin
            out_valid_next = 1'b1;
            out_val_next   = '0;
            out_pri_next   = '0;
            out_last_next  = 1'b1;
        end
        case (cmd.op)
            CMD_INSERT: begin
                count_next    = count_reg + CntW'(1);
                out_stat_next = STAT_ACCEPTED;
            end
            CMD_REMOVE: begin
                count_next    = count_reg - CntW'(1);
                out_val_next  = val_reg[0];
                out_pri_next  = pri_reg[0];
                out_stat_next = STAT_ENTRY;
            end
            CMD_LIST: begin
                out_val_next  = val_reg[0];
                out_pri_next  = pri_reg[0];
                out_stat_next = STAT_ENTRY;
                out_last_next = cmd.list_last;
            end
            CMD_EMPTY: begin
                out_stat_next = STAT_EMPTY;
            end
            CMD_FULL: begin
                out_stat_next = STAT_FULL;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        out_val_reg  <= out_val_next;
        out_pri_reg  <= out_pri_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_value    = out_val_reg;
    assign m_priority = out_pri_reg;
    assign m_status   = out_stat_reg;
    assign m_last     = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_cmd_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != CMD_NONE) |-> stat.out_free)
        else $error("command issued while output register is occupied");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_INSERT) |=> (count_reg == $past(count_reg) + CntW'(1)))
        else $error("insert did not add one entry");

    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_REMOVE || cmd.op == CMD_LIST) |-> !stat.empty)
        else $error("entry read from an empty queue");
`endif

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue with stream ports.
// Input items arrive on the s_ channel: s_tuser carries the action (insert, remove,
// list) and s_tdata carries the value and priority for an insert.
// Results leave on the m_ channel: m_tdata carries the value and priority of a
// removed or listed entry, m_tuser the status, and m_tlast marks the final result
// of each input item.
// Insert, remove and empty or full answers reach the output register in the cycle
// after the item is accepted, and the next item can be accepted in that same cycle,
// so these run at one item per cycle while the receiver keeps up.
// A list enters the list state, then gives one entry per cycle while the output
// register is free, from the front cell as the entry cells rotate back into order.
// The next item is accepted once the final listed entry is in the output register.
// Reset clears the entry count and output valid flag, not the data or entry cells.
// When the receiver holds m_tready low, the result is held and no new item or
// listed entry is taken until the output register is free.
// Inserts into a full queue are dropped and answered with the full status.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_value [31:0], item_priority [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_value [31:0], out_priority [63:32]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    spq_cmd_t                     cmd;
    spq_stat_t                    stat;
    logic [CntW-1:0]              count;
    logic signed [SPQ_DATA_W-1:0] in_value, in_priority;
    logic signed [SPQ_DATA_W-1:0] out_value, out_priority;

    assign in_value    = s_tdata[31:0];
    assign in_priority = s_tdata[63:32];

    spq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .stat     (stat),
        .count    (count),
        .cmd      (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_value    (in_value),
        .in_priority (in_priority),
        .stat        (stat),
        .count       (count),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_value     (out_value),
        .m_priority  (out_priority),
        .m_status    (m_tuser),
        .m_last      (m_tlast)
    );

    assign m_tdata = {out_priority, out_value};

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import spq_pkg::*;

    localparam int QDEPTH = SPQ_DEPTH_DEFAULT;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] val;
        logic [31:0] pri;
        spq_status_t status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] val;
        logic [31:0] pri;
        logic        typed;
        spq_status_t st;
    } row_t;

    // Rows marked typed carry their single result in the table itself.
    localparam row_t DIRECTED [25] = '{
        '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY},
        '{ACT_LIST,   32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY},
        '{ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0, STAT_ENTRY},
        '{ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h0000_0000, 32'h7fff_ffff, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'hffff_ffff, 32'h0000_0000, 1'b1, STAT_ACCEPTED},
        '{ACT_LIST,   32'h0000_0000, 32'h0000_0000, 1'b0, STAT_ENTRY},
        '{ACT_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, STAT_ENTRY},
        '{ACT_INSERT, 32'h1111_0001, 32'hffff_ffff, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0002, 32'h0000_0001, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0003, 32'h0000_0000, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0004, 32'h8000_0000, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0005, 32'h7fff_ffff, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0006, 32'h0000_0005, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0007, 32'h0000_0005, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1111_0008, 32'hffff_fffb, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h5555_5555, 32'h5555_5555, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'haaaa_aaaa, 32'haaaa_aaaa, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h0000_0001, 32'h0000_0005, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h8000_0001, 32'h7fff_fffe, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'h1234_5678, 32'h8000_0001, 1'b1, STAT_ACCEPTED},
        '{ACT_INSERT, 32'hdead_0000, 32'h0000_0000, 1'b1, STAT_FULL},
        '{ACT_LIST,   32'h0000_0000, 32'h0000_0000, 1'b0, STAT_ENTRY},
        '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, STAT_ENTRY}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // item_value [31:0], item_priority [63:32]
    logic [1:0]  s_tuser;   // action [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;   // out_value [31:0], out_priority [63:32]
    logic [1:0]  m_tuser;   // status [1:0]
    logic        m_tlast;

    logic [31:0] held_val [QDEPTH];
    logic [31:0] held_pri [QDEPTH];
    int          held_count = 0;
    result_t     expected_results [$];
    int          bad_results = 0;
    int          burst_left = 0;
    int          hold_cycles = 0;
    int          free_cycles = 0;

    sorted_priority_queue #(.QUEUE_DEPTH(QDEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic predict_item(input logic [1:0] act, input logic [31:0] val,
                                input logic [31:0] pri);
        int slot;
        case (act)
            ACT_INSERT: begin
                if (held_count == QDEPTH) begin
                    expected_results.push_back('{32'd0, 32'd0, STAT_FULL, 1'b1});
                end else begin
                    slot = 0;
                    while (slot < held_count && $signed(held_pri[slot]) > $signed(pri))
                        slot++;
                    for (int i = held_count; i > slot; i--) begin
                        held_val[i] = held_val[i - 1];
                        held_pri[i] = held_pri[i - 1];
                    end
                    held_val[slot] = val;
                    held_pri[slot] = pri;
                    held_count++;
                    expected_results.push_back('{32'd0, 32'd0, STAT_ACCEPTED, 1'b1});
                end
            end
            ACT_REMOVE: begin
                if (held_count == 0) begin
                    expected_results.push_back('{32'd0, 32'd0, STAT_EMPTY, 1'b1});
                end else begin
                    expected_results.push_back('{held_val[0], held_pri[0], STAT_ENTRY, 1'b1});
                    for (int i = 1; i < held_count; i++) begin
                        held_val[i - 1] = held_val[i];
                        held_pri[i - 1] = held_pri[i];
                    end
                    held_count--;
                end
            end
            ACT_LIST: begin
                if (held_count == 0) begin
                    expected_results.push_back('{32'd0, 32'd0, STAT_EMPTY, 1'b1});
                end else begin
                    for (int i = 0; i < held_count; i++)
                        expected_results.push_back('{held_val[i], held_pri[i], STAT_ENTRY,
                                                     logic'(i == held_count - 1)});
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                             input logic [31:0] pri, input logic typed,
                             input spq_status_t st);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {pri, val};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_item(act, val, pri);
        if (typed) begin
            void'(expected_results.pop_back());
            expected_results.push_back('{32'd0, 32'd0, st, 1'b1});
        end
    endtask

    // The receiver mixes long ready stretches with short stalls.
    always @(negedge aclk) begin
        if (hold_cycles != 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (free_cycles != 0) begin
            m_tready <= 1'b1;
            free_cycles <= free_cycles - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                free_cycles <= $urandom_range(20, 80);
            end else begin
                free_cycles <= $urandom_range(0, 3);
                hold_cycles <= $urandom_range(1, 5);
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_results.size() == 0) begin
                if (bad_results < 10)
                    $display("unexpected item: value %h priority %h status %0d last %b",
                             m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
                bad_results++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.val || m_tdata[63:32] !== want.pri ||
                    m_tuser !== want.status || m_tlast !== want.last) begin
                    if (bad_results < 10)
                        $display("mismatch: expected %h/%h/%0d/%b, got %h/%h/%0d/%b",
                                 want.val, want.pri, want.status, want.last,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
                    bad_results++;
                end
            end
        end
    end

    initial begin : stimulus
        int          random_sent;
        int          r;
        int          waited;
        logic [1:0]  act;
        logic [31:0] pri;
        logic        fill_phase;
        logic        drained;

        random_sent = 0;
        drained = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tuser = ACT_INSERT;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 25; k++)
            send_item(DIRECTED[k].act, DIRECTED[k].val, DIRECTED[k].pri,
                      DIRECTED[k].typed, DIRECTED[k].st);

        // Phases alternate between filling and draining so that both the full
        // and the empty queue are reached repeatedly.
        while (random_sent < 125) begin
            if (random_sent == 75 && !drained) begin
                drained = 1'b1;
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
            end
            fill_phase = ((random_sent / 25) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (fill_phase ? 60 : 25))
                act = ACT_INSERT;
            else if (r < (fill_phase ? 80 : 75))
                act = ACT_REMOVE;
            else if (r < 95)
                act = ACT_LIST;
            else
                act = ACT_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                pri = $urandom_range(0, 8) - 32'd4;
            end else if (r < 85) begin
                pri = $urandom;
            end else begin
                case ($urandom_range(0, 3))
                    0: pri = 32'h8000_0000;
                    1: pri = 32'h7fff_ffff;
                    2: pri = 32'h0000_0000;
                    default: pri = 32'hffff_ffff;
                endcase
            end
            send_item(act, $urandom, pri, 1'b0, STAT_ENTRY);
            if (act != ACT_UNUSED)
                random_sent++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0d expected items never arrived", expected_results.size());
            bad_results++;
        end
        if (bad_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
